// File: sv/thms_pkg.sv
// Shared types, codes and widths for the two-axis homing sequencer.
`timescale 1ns / 1ps

package thms_pkg;

	localparam int SpeedW = 20;
	localparam int RatioW = 16;
	localparam int PosW   = 16;
	localparam int PhaseW = 3;
	localparam int DriveW = 2;
	localparam int IdxW   = 2;
	localparam int CfgW   = 20;

	// Half turn in degrees, used for the axis 1 home position
	localparam int HalfTurnDeg = 180;
	localparam int HalfTurnW   = 8;

	// Phase codes
	localparam logic [PhaseW-1:0] PH_IDLE    = 3'd0;
	localparam logic [PhaseW-1:0] PH_A0_FAST = 3'd1;
	localparam logic [PhaseW-1:0] PH_A0_OFF  = 3'd2;
	localparam logic [PhaseW-1:0] PH_A0_BACK = 3'd3;
	localparam logic [PhaseW-1:0] PH_A1_FAST = 3'd4;
	localparam logic [PhaseW-1:0] PH_A1_OFF  = 3'd5;
	localparam logic [PhaseW-1:0] PH_A1_BACK = 3'd6;

	// Drive codes
	localparam logic [DriveW-1:0] DRV_STOP = 2'd0;
	localparam logic [DriveW-1:0] DRV_FWD  = 2'd1;
	localparam logic [DriveW-1:0] DRV_BACK = 2'd2;

	// Command codes
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	// Register indexes
	localparam logic [IdxW-1:0] REG_HOME_SPEED = 2'd0;
	localparam logic [IdxW-1:0] REG_RUN_SPEED  = 2'd1;
	localparam logic [IdxW-1:0] REG_STEPS_DEG  = 2'd2;

	localparam logic [RatioW-1:0] STEPS_DEG_RESET = 16'd256;

	typedef struct packed {
		logic cmd;
		logic sensor_axis0;
		logic sensor_axis1;
	} item_t;

	typedef struct packed {
		logic              active_axis;
		logic [DriveW-1:0] drive;
		logic [SpeedW-1:0] speed_hz;
		logic              speed_to_both;
		logic              load_position;
		logic [PosW-1:0]   position_steps;
		logic              busy_res;
		logic              done_res;
	} result_t;

	typedef struct packed {
		logic [SpeedW-1:0] home_speed;
		logic [SpeedW-1:0] run_speed;
		logic [RatioW-1:0] steps_per_degree;
	} cfg_t;

endpackage

// File: sv/two_axis_homing_sequencer.sv
// Top level of the two-axis homing sequencer.
//
//  channel   | handshake                   | word
//  ----------+-----------------------------+--------------------------------
//  item      | item_valid / item_stall     | item: cmd, sensor levels
//  res       | res_valid / res_stall       | res: drive command, position
//  cfg       | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// Two register stages: the input word register, then the result register.
// One word per cycle sustained while res_stall is low.
// Reset clears the phase to idle and the config to its defaults.
// A stall on a valid result holds both stages; the input takes a new word
// whenever the input register is empty or moving on.
`timescale 1ns / 1ps

module two_axis_homing_sequencer
	import thms_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  item_t           item,
	output logic            res_valid,
	input  logic            res_stall,
	output result_t         res,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [IdxW-1:0] cfg_index,
	input  logic [CfgW-1:0] cfg_data
);

	cfg_t              cfg;
	item_t             item_s1;
	logic              valid_s1;
	logic [PhaseW-1:0] phase_q;
	logic [PhaseW-1:0] phase_next;
	result_t           res_next;
	result_t           res_q;
	logic              res_valid_q;
	logic              adv_s1;
	logic              take_in;

	assign cfg_ready = 1'b1;

	thms_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Flow control
	assign adv_s1     = valid_s1 && (!res_valid_q || !res_stall);
	assign item_stall = valid_s1 && !adv_s1;
	assign take_in    = item_valid && !item_stall;

	// Input word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= item;
		end
	end

	thms_step u_step (
		.phase      (phase_q),
		.item       (item_s1),
		.cfg        (cfg),
		.phase_next (phase_next),
		.res        (res_next)
	);

	// Phase advances as each word leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (adv_s1) begin
			phase_q <= phase_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// File: sv/thms_cfg.sv
// Configuration register file for the homing sequencer.
`timescale 1ns / 1ps

module thms_cfg
	import thms_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  logic [IdxW-1:0] wr_index,
	input  logic [CfgW-1:0] wr_data,
	output cfg_t            cfg
);

	cfg_t cfg_q;

	// Register writes; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.home_speed       <= '0;
			cfg_q.run_speed        <= '0;
			cfg_q.steps_per_degree <= STEPS_DEG_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_HOME_SPEED: cfg_q.home_speed <= wr_data[SpeedW-1:0];
				REG_RUN_SPEED:  cfg_q.run_speed <= wr_data[SpeedW-1:0];
				REG_STEPS_DEG:  cfg_q.steps_per_degree <= wr_data[RatioW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: sv/thms_step.sv
// Next-phase and result logic for one item of the homing sequence.
`timescale 1ns / 1ps

module thms_step
	import thms_pkg::*;
(
	input  logic [PhaseW-1:0] phase,
	input  item_t             item,
	input  cfg_t              cfg,
	output logic [PhaseW-1:0] phase_next,
	output result_t           res
);

	logic [PhaseW-1:0]              cur;
	logic                           active;
	logic                           axis;
	logic                           is_fast;
	logic                           is_off;
	logic                           is_back;
	logic                           sens;
	logic                           exit_now;
	logic [RatioW+HalfTurnW-1:0]    pos_full;

	// Axis 1 home position: 180 * Q8.8 ratio, fraction dropped
	assign pos_full = cfg.steps_per_degree * HalfTurnW'(HalfTurnDeg);

	always_comb begin
		// idle or unused code: a start enters axis 0 fast
		cur = phase;
		if (phase == PH_IDLE || phase > PH_A1_BACK) begin
			cur = (item.cmd == CMD_START) ? PH_A0_FAST : PH_IDLE;
		end

		active  = 1'b1;
		axis    = 1'b0;
		is_fast = 1'b0;
		is_off  = 1'b0;
		is_back = 1'b0;
		unique case (cur)
			PH_A0_FAST: is_fast = 1'b1;
			PH_A0_OFF:  is_off = 1'b1;
			PH_A0_BACK: is_back = 1'b1;
			PH_A1_FAST: begin
				axis    = 1'b1;
				is_fast = 1'b1;
			end
			PH_A1_OFF: begin
				axis   = 1'b1;
				is_off = 1'b1;
			end
			PH_A1_BACK: begin
				axis    = 1'b1;
				is_back = 1'b1;
			end
			default: active = 1'b0;
		endcase

		sens     = axis ? item.sensor_axis1 : item.sensor_axis0;
		exit_now = is_off ? !sens : sens;

		res        = '0;
		phase_next = cur;
		if (active) begin
			res.active_axis = axis;
			res.speed_hz    = is_fast ? cfg.home_speed : (cfg.home_speed >> 1);
			res.busy_res    = 1'b1;
			if (!exit_now) begin
				res.drive = is_back ? DRV_BACK : DRV_FWD;
			end else if (!is_back) begin
				res.drive  = DRV_STOP;
				phase_next = cur + PhaseW'(1);
			end else if (!axis) begin
				// axis 0 homed: zero its position, go on to axis 1
				res.load_position = 1'b1;
				phase_next        = PH_A1_FAST;
			end else begin
				// axis 1 homed: load half-turn position, restore run speed
				res.load_position  = 1'b1;
				res.position_steps = pos_full[RatioW+HalfTurnW-1:HalfTurnW];
				res.speed_hz       = cfg.run_speed;
				res.speed_to_both  = 1'b1;
				res.done_res       = 1'b1;
				res.busy_res       = 1'b0;
				phase_next         = PH_IDLE;
			end
		end
	end

endmodule

// File: tb/homing_checker.sv
// Checker for the homing sequencer: predicts each result word and compares it.
`timescale 1ns / 1ps

module homing_checker
	import thms_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  logic            item_stall,
	input  item_t           item,
	input  logic            res_valid,
	input  logic            res_stall,
	input  result_t         res,
	input  logic            cfg_valid,
	input  logic            cfg_ready,
	input  logic [IdxW-1:0] cfg_index,
	input  logic [CfgW-1:0] cfg_data,
	output int              errors,
	output int              pending
);

	// Q8.8 fraction bits of steps_per_degree
	localparam int FracBits = 8;

	logic [PhaseW-1:0] phase_q;
	cfg_t              regs;
	result_t           drive_cmds[$];
	result_t           want;
	int                mismatch_count = 0;

	assign errors = mismatch_count;

	// Advance the phase for one word and build the command it should produce
	task automatic predict_drive_cmd(input item_t w, output result_t r);
		logic        sens;
		logic        leave;
		logic        fast;
		logic        back;
		logic [31:0] prod;
		r = '0;
		if (phase_q == PH_IDLE || phase_q > PH_A1_BACK) begin
			phase_q = (w.cmd == CMD_START) ? PH_A0_FAST : PH_IDLE;
		end
		if (phase_q != PH_IDLE) begin
			r.active_axis = (phase_q >= PH_A1_FAST);
			sens = r.active_axis ? w.sensor_axis1 : w.sensor_axis0;
			fast = (phase_q == PH_A0_FAST || phase_q == PH_A1_FAST);
			back = (phase_q == PH_A0_BACK || phase_q == PH_A1_BACK);
			r.speed_hz = fast ? regs.home_speed : (regs.home_speed >> 1);
			// off phase leaves when the sensor clears, the others when it trips
			leave = (fast || back) ? sens : ~sens;
			r.busy_res = 1'b1;
			if (!leave) begin
				r.drive = back ? DRV_BACK : DRV_FWD;
			end else begin
				r.drive = DRV_STOP;
				if (!back) begin
					phase_q = phase_q + 1'b1;
				end else begin
					r.load_position = 1'b1;
					if (!r.active_axis) begin
						// axis 0 homes to position zero
						phase_q = PH_A1_FAST;
					end else begin
						prod = HalfTurnDeg * 32'(regs.steps_per_degree);
						r.position_steps = PosW'(prod >> FracBits);
						r.speed_hz = regs.run_speed;
						r.speed_to_both = 1'b1;
						r.done_res = 1'b1;
						r.busy_res = 1'b0;
						phase_q = PH_IDLE;
					end
				end
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			mismatch_count++;
			$display("%0t: %s expected %0h, actual %0h", $time, name, exp_v, got_v);
		end
	endtask

	// Watch all three channels at each edge; results are matched before new
	// words are queued so a same-edge word never pairs with its own result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q = PH_IDLE;
			regs.home_speed = '0;
			regs.run_speed = '0;
			regs.steps_per_degree = STEPS_DEG_RESET;
			drive_cmds.delete();
			pending <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (drive_cmds.size() == 0) begin
					mismatch_count++;
					$display("%0t: result word with none expected, actual %h", $time, res);
				end else begin
					want = drive_cmds.pop_front();
					check_field("active_axis", 32'(want.active_axis), 32'(res.active_axis));
					check_field("drive", 32'(want.drive), 32'(res.drive));
					check_field("speed_hz", 32'(want.speed_hz), 32'(res.speed_hz));
					check_field("speed_to_both", 32'(want.speed_to_both),
						32'(res.speed_to_both));
					check_field("load_position", 32'(want.load_position),
						32'(res.load_position));
					check_field("position_steps", 32'(want.position_steps),
						32'(res.position_steps));
					check_field("busy_res", 32'(want.busy_res), 32'(res.busy_res));
					check_field("done_res", 32'(want.done_res), 32'(res.done_res));
				end
			end
			if (item_valid && !item_stall) begin
				predict_drive_cmd(item, want);
				drive_cmds.push_back(want);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_HOME_SPEED: regs.home_speed = cfg_data[SpeedW-1:0];
					REG_RUN_SPEED:  regs.run_speed = cfg_data[SpeedW-1:0];
					REG_STEPS_DEG:  regs.steps_per_degree = cfg_data[RatioW-1:0];
					default: ;
				endcase
			end
			pending <= drive_cmds.size();
		end
	end

endmodule

// File: tb/tb.sv
// Testbench top: stimulus, idling, config phases and verdict for the sequencer.
`timescale 1ns / 1ps

module tb;
	import thms_pkg::*;

	localparam int CycleLimit  = 400000;
	localparam int NumPhases   = 8;
	localparam int PhaseWords  = 205;
	localparam int DrainCycles = 8;

	logic            clk;
	logic            arst_n = 1'b0;
	logic            item_valid = 1'b0;
	logic            item_stall;
	item_t           item = '0;
	logic            res_valid;
	logic            res_stall = 1'b0;
	result_t         res;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [IdxW-1:0] cfg_index = '0;
	logic [CfgW-1:0] cfg_data = '0;
	int              errors;
	int              pending;

	int              send_idle_pct = 0;
	int              recv_stall_pct = 0;
	int              hold_left = 0;
	int              sent_count = 0;
	int              cycle_count = 0;
	logic            open_start = 1'b0;

	two_axis_homing_sequencer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	homing_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.errors     (errors),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("two_axis_homing_sequencer test failed");
		$finish;
	end

	// Result side: long hold-off when requested, random stalls otherwise
	always @(posedge clk) begin
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left--;
		end else begin
			res_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic item_t mk(input logic c, input logic s0, input logic s1);
		item_t w;
		w.cmd = c;
		w.sensor_axis0 = s0;
		w.sensor_axis1 = s1;
		return w;
	endfunction

	// Offer one word; stall is sampled mid-cycle, where it is settled
	task automatic send_word(input item_t w);
		logic stalled;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		do begin
			@(negedge clk);
			stalled = item_stall;
			@(posedge clk);
		end while (stalled);
		sent_count++;
	endtask

	// Stop offering and wait until every expected word has come back
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic put_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] val);
		logic ready_seen;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			ready_seen = cfg_ready;
			@(posedge clk);
		end while (!ready_seen);
	endtask

	task automatic write_cfg(input logic [CfgW-1:0] home, input logic [CfgW-1:0] run,
		input logic [CfgW-1:0] ratio);
		put_reg(REG_HOME_SPEED, home);
		put_reg(REG_RUN_SPEED, run);
		put_reg(REG_STEPS_DEG, ratio);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// One homing phase as a sensor would see it: a few words at the holding
	// level, then one at the exit level; now and then a level is flipped
	task automatic sensor_run(input logic axis, input logic hold_level);
		int    n;
		logic  lvl;
		item_t w;
		n = $urandom_range(0, 4);
		for (int i = 0; i <= n; i++) begin
			lvl = (i == n) ? ~hold_level : hold_level;
			if ($urandom_range(99) < 3) lvl = ~lvl;
			w.cmd = (open_start || $urandom_range(19) == 0) ? CMD_START : CMD_TICK;
			open_start = 1'b0;
			w.sensor_axis0 = axis ? logic'($urandom_range(1)) : lvl;
			w.sensor_axis1 = axis ? lvl : logic'($urandom_range(1));
			send_word(w);
		end
	endtask

	// Full sequence: fast, off, back on axis 0, then the same on axis 1
	task automatic homing_run();
		open_start = 1'b1;
		sensor_run(1'b0, 1'b0);
		sensor_run(1'b0, 1'b1);
		sensor_run(1'b0, 1'b0);
		sensor_run(1'b1, 1'b0);
		sensor_run(1'b1, 1'b1);
		sensor_run(1'b1, 1'b0);
	endtask

	initial begin
		int target;
		int burst;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at the reset configuration
		// idle ticks give all-zero results
		send_word(mk(CMD_TICK, 1'b0, 1'b0));
		send_word(mk(CMD_TICK, 1'b1, 1'b1));
		// full sequence with starts while busy
		send_word(mk(CMD_START, 1'b0, 1'b1));
		send_word(mk(CMD_TICK, 1'b1, 1'b0));
		send_word(mk(CMD_TICK, 1'b1, 1'b1));
		send_word(mk(CMD_START, 1'b0, 1'b0));
		send_word(mk(CMD_TICK, 1'b0, 1'b1));
		send_word(mk(CMD_TICK, 1'b1, 1'b0));
		send_word(mk(CMD_TICK, 1'b1, 1'b0));
		send_word(mk(CMD_START, 1'b0, 1'b1));
		send_word(mk(CMD_TICK, 1'b0, 1'b1));
		send_word(mk(CMD_TICK, 1'b1, 1'b0));
		send_word(mk(CMD_TICK, 1'b1, 1'b0));
		send_word(mk(CMD_TICK, 1'b0, 1'b1));
		send_word(mk(CMD_TICK, 1'b0, 1'b0));
		// start with the sensor already on: fast phase exits at once
		send_word(mk(CMD_START, 1'b1, 1'b0));
		send_word(mk(CMD_TICK, 1'b0, 1'b0));
		send_word(mk(CMD_TICK, 1'b1, 1'b0));
		send_word(mk(CMD_START, 1'b0, 1'b1));
		send_word(mk(CMD_TICK, 1'b0, 1'b0));
		send_word(mk(CMD_TICK, 1'b0, 1'b1));
		drain();

		// Random phases, each with its own configuration and idling mode
		for (int p = 0; p < NumPhases; p++) begin
			case (p)
				0: write_cfg(20'hFFFFF, 20'hFFFFF, 20'h0FFFF);
				1: write_cfg(20'h00000, 20'h00000, 20'h00000);
				2: write_cfg(20'h00001, 20'hFFFFF, 20'h00001);
				default: write_cfg(20'($urandom_range(0, 20'hFFFFF)),
					20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 16'hFFFF)));
			endcase
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
				default: begin send_idle_pct = 8; recv_stall_pct = 8; end
			endcase
			// long receiver hold-off while the sender keeps offering
			if (p == 4) hold_left = 300;
			target = sent_count + PhaseWords;
			while (sent_count < target) begin
				if ($urandom_range(9) < 8) begin
					homing_run();
				end else begin
					burst = $urandom_range(1, 6);
					repeat (burst) send_word(item_t'($urandom_range(0, 7)));
				end
			end
			drain();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (DrainCycles) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("two_axis_homing_sequencer test passed");
		end else begin
			$display("two_axis_homing_sequencer test failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
sv/thms_pkg.sv
sv/thms_cfg.sv
sv/thms_step.sv
sv/two_axis_homing_sequencer.sv
tb/homing_checker.sv
tb/tb.sv
